>>> src/rgbc_pkg.sv
// Shared types, constants and helpers for the RGB 3x3 convolution block.
package rgbc_pkg;

    localparam int MaxWidth     = 1024;
    localparam int ColBits      = $clog2(MaxWidth);
    localparam int CoefFracBits = 8;

    typedef enum logic [2:0] {
        REG_WIDTH   = 3'd0,
        REG_HEIGHT  = 3'd1,
        REG_OFFSET  = 3'd2,
        REG_K_TOP   = 3'd3,
        REG_K_MID   = 3'd4,
        REG_K_BOT   = 3'd5
    } reg_index_t;

    typedef logic [23:0] pixel_t;

    // Signed product of a Q8.8 tap and an 8-bit pixel.
    typedef logic signed [24:0] prod_t;
    // Rounded tap term.
    typedef logic signed [16:0] term_t;

    // Partial result handed along the chain of tap cells.
    typedef struct packed {
        logic                valid;
        logic                last;
        logic signed [20:0]  sum_r;
        logic signed [20:0]  sum_g;
        logic signed [20:0]  sum_b;
    } acc_t;

    // Round a product half away from zero to an integer.
    function automatic term_t round_term(input prod_t p);
        logic [24:0] mag;
        logic [24:0] r;
        mag = p[24] ? 25'(-p) : 25'(p);
        r   = (mag + 25'(1 << (CoefFracBits - 1))) >> CoefFracBits;
        return p[24] ? -term_t'(r[16:0]) : term_t'(r[16:0]);
    endfunction

    function automatic logic [7:0] sat8(input logic signed [20:0] s);
        if (s < 0) return 8'd0;
        if (s > 21'sd255) return 8'd255;
        return s[7:0];
    endfunction

endpackage

>>> src/rgbc_tap_cell.sv
// One tap of the filter: multiply three channels and add to the passing sums.
module rgbc_tap_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic signed [15:0]   coef,
    input  rgbc_pkg::pixel_t     pix,
    input  rgbc_pkg::acc_t       acc_in,
    output rgbc_pkg::acc_t       acc_out
);
    rgbc_pkg::acc_t acc_reg, acc_next;
    rgbc_pkg::prod_t pr, pg, pb;

    always_comb begin
        pr = rgbc_pkg::prod_t'(coef) * $signed({1'b0, pix[23:16]});
        pg = rgbc_pkg::prod_t'(coef) * $signed({1'b0, pix[15:8]});
        pb = rgbc_pkg::prod_t'(coef) * $signed({1'b0, pix[7:0]});
        acc_next = acc_in;
        acc_next.sum_r = acc_in.sum_r + 21'(rgbc_pkg::round_term(pr));
        acc_next.sum_g = acc_in.sum_g + 21'(rgbc_pkg::round_term(pg));
        acc_next.sum_b = acc_in.sum_b + 21'(rgbc_pkg::round_term(pb));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc_out = acc_reg;
endmodule

>>> src/rgb_convolution_3x3.sv
// Top level: line buffers, window, chain of nine tap cells and output stage.
// Throughput: one pixel per cycle; the line buffer read port and the tap chain
// advance together, one word per cycle, and stall as a whole on backpressure.
// Reset: synchronous active-low aresetn clears indices, window, chain valids
// and registers to their defaults; line buffers are not cleared.
module rgb_convolution_3x3 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red_out,
    output logic [7:0]  m_green_out,
    output logic [7:0]  m_blue_out,
    output logic        m_frame_end
);
    localparam int CB = rgbc_pkg::ColBits;

    logic [10:0] width_reg;
    logic [11:0] height_reg;
    logic        offset_reg;
    logic [47:0] krow_reg [3];

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 11'd640;
            height_reg <= 12'd480;
            offset_reg <= 1'b0;
            krow_reg[0] <= '0;
            krow_reg[1] <= 48'd16777216;
            krow_reg[2] <= '0;
        end else if (cfg_valid) begin
            case (rgbc_pkg::reg_index_t'(cfg_index))
                rgbc_pkg::REG_WIDTH:  width_reg  <= cfg_data[10:0];
                rgbc_pkg::REG_HEIGHT: height_reg <= cfg_data[11:0];
                rgbc_pkg::REG_OFFSET: offset_reg <= cfg_data[0];
                rgbc_pkg::REG_K_TOP:  krow_reg[0] <= cfg_data;
                rgbc_pkg::REG_K_MID:  krow_reg[1] <= cfg_data;
                rgbc_pkg::REG_K_BOT:  krow_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advance: whole pipe moves when the output slot is free or its word is being taken.
    logic adv;
    logic out_valid_reg;
    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    logic acc_in;
    assign acc_in = s_valid && s_ready;

    logic [11:0] w_eff, h_eff;
    always_comb begin
        if (width_reg < 11'd3) w_eff = 12'd3;
        else if (width_reg > 11'(rgbc_pkg::MaxWidth)) w_eff = 12'(rgbc_pkg::MaxWidth);
        else w_eff = {1'b0, width_reg};
        h_eff = (height_reg < 12'd3) ? 12'd3 : height_reg;
    end

    // Stage 0: index update and memory read.
    logic [11:0] col_reg, col_next, row_reg, row_next;
    logic [11:0] col, row;
    always_comb begin
        col = col_reg;
        row = row_reg;
        if (col >= w_eff) begin
            col = '0;
            row = row + 12'd1;
        end
        if (row >= h_eff) row = '0;
        col_next = col + 12'd1;
        row_next = row;
        if (col_next >= w_eff) begin
            col_next = '0;
            row_next = row + 12'd1;
            if (row_next >= h_eff) row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (acc_in) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line buffers: one memory holds both rows; read and write same address.
    logic [47:0] line_mem [rgbc_pkg::MaxWidth];
    logic [47:0] line_rd_reg;
    rgbc_pkg::pixel_t pix_in, pix1_reg;
    logic v1_reg, emit1_reg, last1_reg;
    logic [CB-1:0] addr1_reg;
    assign pix_in = {s_red, s_green, s_blue};

    always_ff @(posedge aclk) begin
        if (acc_in) begin
            line_rd_reg <= line_mem[col[CB-1:0]];
            pix1_reg    <= pix_in;
            addr1_reg   <= col[CB-1:0];
            emit1_reg   <= (row >= 12'd2) && (col >= 12'd2);
            last1_reg   <= (row == h_eff - 12'd1) && (col == w_eff - 12'd1);
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= acc_in;
    end

    // No bypass needed: a pixel read back-to-back at the same column cannot occur (w >= 3),
    // so the write-back from the registered address and pixel is safe.
    always_ff @(posedge aclk) begin
        if (adv && v1_reg) begin
            line_mem[addr1_reg] <= {line_rd_reg[23:0], pix1_reg};
        end
    end

    // Window: shift columns in on each valid pixel.
    rgbc_pkg::pixel_t win_reg [3][3];
    logic v2_reg, last2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++) win_reg[r][c] <= '0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg && emit1_reg;
            if (v1_reg) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= line_rd_reg[47:24];
                win_reg[1][2] <= line_rd_reg[23:0];
                win_reg[2][2] <= pix1_reg;
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) last2_reg <= last1_reg;
    end

    // Snapshot of the window enters a delay line so each cell sees its tap.
    rgbc_pkg::pixel_t snap_reg [8][9];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int t = 0; t < 9; t++) snap_reg[0][t] <= win_reg[t / 3][t % 3];
            for (int s = 1; s < 8; s++)
                for (int t = 0; t < 9; t++) snap_reg[s][t] <= snap_reg[s-1][t];
        end
    end

    rgbc_pkg::acc_t chain [10];
    always_comb begin
        chain[0] = '0;
        chain[0].valid = v2_reg;
        chain[0].last  = last2_reg;
    end

    for (genvar t = 0; t < 9; t++) begin : g_tap
        rgbc_pkg::pixel_t tap_pix;
        // first cell reads the live window, later cells its delayed copies
        if (t == 0) begin : g_head
            assign tap_pix = win_reg[0][0];
        end else begin : g_rest
            assign tap_pix = snap_reg[t-1][t];
        end
        rgbc_tap_cell u_tap (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .coef    (krow_reg[t / 3][16*(t % 3) +: 16]),
            .pix     (tap_pix),
            .acc_in  (chain[t]),
            .acc_out (chain[t+1])
        );
    end

    // Output stage: offset, saturate, hold until taken.
    rgbc_pkg::acc_t fin;
    logic signed [20:0] ofs;
    logic [7:0] r_reg, g_reg, b_reg;
    logic last_reg;
    assign fin = chain[9];
    assign ofs = offset_reg ? 21'sd127 : 21'sd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid_reg <= 1'b0;
        else if (adv) out_valid_reg <= fin.valid;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            r_reg    <= rgbc_pkg::sat8(fin.sum_r + ofs);
            g_reg    <= rgbc_pkg::sat8(fin.sum_g + ofs);
            b_reg    <= rgbc_pkg::sat8(fin.sum_b + ofs);
            last_reg <= fin.last;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_red_out   = r_reg;
    assign m_green_out = g_reg;
    assign m_blue_out  = b_reg;
    assign m_frame_end = last_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red_out))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while pipe stalled");
    a_col: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= 12'(rgbc_pkg::MaxWidth))
        else $error("column index out of range");
endmodule

>>> tb/rgb_conv_checker.sv
// Checker for the RGB 3x3 convolution: watches all channels, predicts and compares results.
module rgb_conv_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_red_out,
    input  logic [7:0]  m_green_out,
    input  logic [7:0]  m_blue_out,
    input  logic        m_frame_end,
    output int          fail_count,
    output int          pending,
    output int          result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } filtered_pixel_t;

    logic [10:0] width_reg;
    logic [11:0] height_reg;
    logic        offset_on;
    logic [47:0] kernel_rows [3];

    rgbc_pkg::pixel_t older_row [rgbc_pkg::MaxWidth];
    rgbc_pkg::pixel_t newer_row [rgbc_pkg::MaxWidth];
    rgbc_pkg::pixel_t win [3][3];
    int     row_pos;
    int     col_pos;
    int     fails;

    filtered_pixel_t filtered_q [$];

    initial begin
        for (int i = 0; i < rgbc_pkg::MaxWidth; i++) begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
        fails = 0;
    end

    function automatic logic [7:0] convolve_channel(input int shift);
        int sum;
        int tap;
        int prod;
        int mag;
        int rounded;
        sum = 0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                tap = int'($signed(kernel_rows[r][16*c +: 16]));
                prod = tap * int'((win[r][c] >> shift) & 24'hFF);
                mag = (prod < 0) ? -prod : prod;
                rounded = (mag + (1 << (rgbc_pkg::CoefFracBits - 1)))
                          >>> rgbc_pkg::CoefFracBits;
                sum += (prod < 0) ? -rounded : rounded;
            end
        end
        if (offset_on)
            sum += 127;
        if (sum < 0)
            return 8'd0;
        if (sum > 255)
            return 8'd255;
        return sum[7:0];
    endfunction

    always @(posedge aclk) begin
        int w;
        int h;
        rgbc_pkg::pixel_t pix;
        filtered_pixel_t exp_px;
        if (!aresetn) begin
            width_reg = 11'd640;
            height_reg = 12'd480;
            offset_on = 1'b0;
            kernel_rows[0] = '0;
            kernel_rows[1] = 48'h0000_0100_0000;
            kernel_rows[2] = '0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win[r][c] = '0;
            row_pos = 0;
            col_pos = 0;
            filtered_q.delete();
            result_count <= 0;
        end else begin
            // compare first: a result never belongs to a word of the same edge
            if (m_valid && m_ready) begin
                if (filtered_q.size() == 0) begin
                    $display("%0t: unexpected result word r=%0d g=%0d b=%0d last=%0b",
                             $time, m_red_out, m_green_out, m_blue_out, m_frame_end);
                    fails++;
                end else begin
                    exp_px = filtered_q.pop_front();
                    if (m_red_out !== exp_px.red) begin
                        $display("%0t: red_out expected %0d actual %0d",
                                 $time, exp_px.red, m_red_out);
                        fails++;
                    end
                    if (m_green_out !== exp_px.green) begin
                        $display("%0t: green_out expected %0d actual %0d",
                                 $time, exp_px.green, m_green_out);
                        fails++;
                    end
                    if (m_blue_out !== exp_px.blue) begin
                        $display("%0t: blue_out expected %0d actual %0d",
                                 $time, exp_px.blue, m_blue_out);
                        fails++;
                    end
                    if (m_frame_end !== exp_px.last) begin
                        $display("%0t: frame_end expected %0b actual %0b",
                                 $time, exp_px.last, m_frame_end);
                        fails++;
                    end
                end
                result_count <= result_count + 1;
            end

            if (cfg_valid && cfg_ready) begin
                case (rgbc_pkg::reg_index_t'(cfg_index))
                    rgbc_pkg::REG_WIDTH:  width_reg = cfg_data[10:0];
                    rgbc_pkg::REG_HEIGHT: height_reg = cfg_data[11:0];
                    rgbc_pkg::REG_OFFSET: offset_on = cfg_data[0];
                    rgbc_pkg::REG_K_TOP:  kernel_rows[0] = cfg_data;
                    rgbc_pkg::REG_K_MID:  kernel_rows[1] = cfg_data;
                    rgbc_pkg::REG_K_BOT:  kernel_rows[2] = cfg_data;
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                w = (width_reg < 3) ? 3 :
                    ((width_reg > rgbc_pkg::MaxWidth) ? rgbc_pkg::MaxWidth : width_reg);
                h = (height_reg < 3) ? 3 : height_reg;
                pix = {s_red, s_green, s_blue};
                if (col_pos >= w) begin
                    col_pos = 0;
                    row_pos++;
                end
                if (row_pos >= h)
                    row_pos = 0;
                for (int r = 0; r < 3; r++) begin
                    win[r][0] = win[r][1];
                    win[r][1] = win[r][2];
                end
                win[0][2] = older_row[col_pos];
                win[1][2] = newer_row[col_pos];
                win[2][2] = pix;
                older_row[col_pos] = newer_row[col_pos];
                newer_row[col_pos] = pix;
                if (row_pos >= 2 && col_pos >= 2) begin
                    exp_px.red   = convolve_channel(16);
                    exp_px.green = convolve_channel(8);
                    exp_px.blue  = convolve_channel(0);
                    exp_px.last  = (row_pos == h - 1) && (col_pos == w - 1);
                    filtered_q.push_back(exp_px);
                end
                col_pos++;
                if (col_pos >= w) begin
                    col_pos = 0;
                    row_pos++;
                    if (row_pos >= h)
                        row_pos = 0;
                end
            end
        end
        pending <= filtered_q.size();
        fail_count <= fails;
    end

endmodule

>>> tb/rgb_convolution_3x3_test.sv
// Testbench top for the RGB 3x3 convolution: clock, reset, stimulus and verdict.
module rgb_convolution_3x3_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam int DrainCycles = 30;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_red;
    logic [7:0]  s_green;
    logic [7:0]  s_blue;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_red_out;
    logic [7:0]  m_green_out;
    logic [7:0]  m_blue_out;
    logic        m_frame_end;

    int fail_count;
    int pending;
    int result_count;

    int burst_left;
    int pixel_count;
    int frame_count;
    int cur_w;
    int cur_h;
    int pos_col;
    int pos_row;
    int stall_left;
    int stall_mode;

    rgb_convolution_3x3 dut (.*);

    rgb_conv_checker checker_i (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // receiver: stretches of always ready, coin flips, long stalls, mostly ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(1, 60);
            end
            stall_left--;
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                2: m_ready <= 1'b0;
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [47:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    task automatic apply_size(input logic [47:0] wraw, input logic [47:0] hraw);
        int w;
        int h;
        w = int'(wraw[10:0]);
        h = int'(hraw[11:0]);
        cur_w = (w < 3) ? 3 : ((w > rgbc_pkg::MaxWidth) ? rgbc_pkg::MaxWidth : w);
        cur_h = (h < 3) ? 3 : h;
        if (pos_col >= cur_w) begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= cur_h)
            pos_row = 0;
    endtask

    task automatic configure(input logic [47:0] wraw, input logic [47:0] hraw,
                             input logic [47:0] off, input logic [47:0] ktop,
                             input logic [47:0] kmid, input logic [47:0] kbot);
        cfg_write(rgbc_pkg::REG_WIDTH, wraw);
        cfg_write(rgbc_pkg::REG_HEIGHT, hraw);
        cfg_write(rgbc_pkg::REG_OFFSET, off);
        cfg_write(rgbc_pkg::REG_K_TOP, ktop);
        cfg_write(rgbc_pkg::REG_K_MID, kmid);
        cfg_write(rgbc_pkg::REG_K_BOT, kbot);
        cfg_valid <= 1'b0;
        apply_size(wraw, hraw);
    endtask

    // hold valid through the burst, drop it for a random gap, which may be empty, between bursts
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        s_valid <= 1'b1;
        s_red   <= r;
        s_green <= g;
        s_blue  <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        burst_left--;
        pixel_count++;
        pos_col++;
        if (pos_col >= cur_w) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= cur_h) begin
                pos_row = 0;
                frame_count++;
            end
        end
    endtask

    function automatic logic [7:0] pick_channel(input int kind);
        logic [7:0] edges [6];
        edges = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127};
        if (kind == 1)
            return edges[$urandom_range(0, 5)];
        return 8'($urandom);
    endfunction

    task automatic send_random_pixel(input int kind);
        send_pixel(pick_channel(kind), pick_channel(kind), pick_channel(kind));
    endtask

    task automatic finish_frame(input int kind);
        do
            send_random_pixel(kind);
        while (pos_col != 0 || pos_row != 0);
    endtask

    // wait out every expected word plus the pipeline depth
    task automatic drain;
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_tap();
        logic [15:0] edges [4];
        edges = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0100};
        case ($urandom_range(0, 7))
            0: return edges[$urandom_range(0, 3)];
            1: return 16'($urandom);
            default: return 16'($urandom_range(0, 1024) - 512);
        endcase
    endfunction

    function automatic logic [47:0] pick_kernel_row();
        return {pick_tap(), pick_tap(), pick_tap()};
    endfunction

    function automatic logic [47:0] pick_width();
        case ($urandom_range(0, 9))
            0: return 48'($urandom_range(0, 2));
            1: return 48'($urandom_range(13, 40));
            default: return 48'($urandom_range(3, 12));
        endcase
    endfunction

    function automatic logic [47:0] pick_height();
        if ($urandom_range(0, 7) == 0)
            return 48'($urandom_range(0, 2));
        return 48'($urandom_range(3, 8));
    endfunction

    initial begin
        int nframes;
        int partial;
        int kind;
        logic [47:0] shrink_w;
        logic [47:0] shrink_h;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= rgbc_pkg::REG_WIDTH;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_red     <= '0;
        s_green   <= '0;
        s_blue    <= '0;
        burst_left = 0;
        pixel_count = 0;
        frame_count = 0;
        pos_col = 0;
        pos_row = 0;
        cur_w = 640;
        cur_h = 480;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // identity kernel on extreme pixels; an unused index is ignored
        cfg_write(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
        configure(48'd3, 48'd3, 48'd0, 48'd0, 48'h0000_0100_0000, 48'd0);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2) ? 8'd255 : 8'd0, (i % 3) ? 8'd0 : 8'd255, 8'(i * 31));
        drain();

        // widths and heights below 3 act as 3; largest positive taps saturate high
        configure(48'd1, 48'd0, 48'd1, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        finish_frame(0);
        drain();

        // most negative taps on full pixels saturate to zero
        configure(48'd2, 48'd2, 48'd0, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        for (int i = 0; i < 9; i++)
            send_pixel(8'd255, 8'd255, 8'd255);
        drain();

        // junk above the width and height fields is dropped
        configure({37'h1F_FFFF_FFFF, 11'd7}, {36'hABC_DEF1_2, 12'd4}, 48'd1,
                  pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
        finish_frame(1);
        drain();

        while (pixel_count < 1050) begin
            kind = ($urandom_range(0, 4) == 0) ? 1 : 0;
            configure(pick_width(), pick_height(), 48'($urandom_range(0, 1)),
                      pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
            if ($urandom_range(0, 4) == 0) begin
                // shrink or keep the width and pick a new height partway through a frame
                partial = $urandom_range(1, cur_w * cur_h - 1);
                repeat (partial) send_random_pixel(kind);
                drain();
                shrink_w = 48'($urandom_range(0, cur_w));
                shrink_h = pick_height();
                cfg_write(rgbc_pkg::REG_WIDTH, shrink_w);
                cfg_write(rgbc_pkg::REG_HEIGHT, shrink_h);
                cfg_valid <= 1'b0;
                apply_size(shrink_w, shrink_h);
                // send at least one word so the block applies the new size
                finish_frame(kind);
            end else begin
                nframes = $urandom_range(1, 2);
                repeat (nframes) finish_frame(kind);
            end
            drain();
        end

        $display("Sent %0d pixels in %0d frames; checked %0d filtered pixels.",
                 pixel_count, frame_count, result_count);
        $display("Covered size clamping, width change mid-frame, offset and saturation.");
        if (fail_count == 0)
            $display("rgb_convolution_3x3_test passed");
        else
            $display("rgb_convolution_3x3_test failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("rgb_convolution_3x3_test failed");
        $finish;
    end

endmodule
